### rtl/stream_min_max_mean_variance_defines.svh
// Assertion macros used by the checker file of the statistics block.
`ifndef STREAM_MIN_MAX_MEAN_VARIANCE_DEFINES_SVH
`define STREAM_MIN_MAX_MEAN_VARIANCE_DEFINES_SVH

// Same-cycle implication, gated off during reset
`define SMMV_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("smmv assertion failed");

// Next-cycle implication, gated off during reset
`define SMMV_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("smmv assertion failed");

`endif

### rtl/smmv_pkg.sv
`default_nettype none
package smmv_pkg;

    // Parameter defaults
    localparam int unsigned MAX_COUNT_DEF    = 65536;
    localparam int unsigned SAMPLE_WIDTH_DEF = 24;
    localparam int unsigned FRAC_BITS_DEF    = 16;

    // Fixed field and accumulator widths
    localparam int unsigned IN_W   = 24;
    localparam int unsigned CNT_W  = 17;
    localparam int unsigned SUM_W  = 41;
    localparam int unsigned SQ_W   = 63;
    localparam int unsigned SMAG_W = 40;
    localparam int unsigned MEAN_W = 40;
    localparam int unsigned VAR_W  = 63;
    localparam int unsigned STD_W  = 40;
    localparam int unsigned DIFF_W = 80;
    localparam int unsigned NSQ_W  = 34;
    localparam int unsigned ROOT_W = 40;

endpackage
`default_nettype wire

### rtl/stream_min_max_mean_variance.sv
`default_nettype none
// Streaming statistics: running max, min, count, mean, variance, std deviation.
// Input channel (i_in_valid / o_in_ready) carries one signed sample and a
// last-of-set flag per transaction. Output channel (o_out_valid / i_out_ready)
// carries one result per set: max, min, count, mean, variance and standard
// deviation (the last three in fixed point with FRAC_BITS fraction bits).
// Each sample is accepted with compare and sum, squared on the 24x24
// multiplier and added to the sum of squares; no new sample is taken until
// it is added. A sample marked last is followed by the result computation on
// one shift-add multiplier, one restoring divider and one digit-by-digit
// square root unit, in turn: n times the sum of squares, the squared sum,
// the variance (difference over n squared), the mean (sum over n) and the
// standard deviation (root of the variance). o_in_ready is low throughout.
// Beyond MAX_COUNT samples further samples are dropped and the overflow flag
// is set. The result waits in output registers; while the receiver stalls,
// new samples are taken, and a following set only waits in its final state.
// Reset (synchronous, active low) clears all accumulators and drops any
// waiting result.
module stream_min_max_mean_variance #(
    parameter int unsigned MAX_COUNT    = smmv_pkg::MAX_COUNT_DEF,
    parameter int unsigned SAMPLE_WIDTH = smmv_pkg::SAMPLE_WIDTH_DEF,
    parameter int unsigned FRAC_BITS    = smmv_pkg::FRAC_BITS_DEF
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_in_valid,
    output logic                               o_in_ready,
    input  logic signed [smmv_pkg::IN_W-1:0]   i_sample,
    input  logic                               i_last_sample,
    output logic                               o_out_valid,
    input  logic                               i_out_ready,
    output logic signed [smmv_pkg::IN_W-1:0]   o_max_value,
    output logic signed [smmv_pkg::IN_W-1:0]   o_min_value,
    output logic [smmv_pkg::CNT_W-1:0]         o_sample_count,
    output logic signed [smmv_pkg::MEAN_W-1:0] o_mean_fixed,
    output logic [smmv_pkg::VAR_W-1:0]         o_variance_fixed,
    output logic [smmv_pkg::STD_W-1:0]         o_std_dev_fixed,
    output logic                               o_count_overflow
);
    import smmv_pkg::*;

    localparam int unsigned DIV_W  = DIFF_W + 2 * FRAC_BITS;
    localparam int unsigned STEP_W = $clog2(DIV_W);
    localparam int unsigned REM_W  = NSQ_W + 1;
    localparam int unsigned SR_W   = ROOT_W + 3;
    localparam int unsigned SW     = SAMPLE_WIDTH;

    typedef enum logic [13:0] {
        S_IDLE = 14'b00000000000001,
        S_SQ   = 14'b00000000000010,
        S_ACC  = 14'b00000000000100,
        S_PREP = 14'b00000000001000,
        S_MUL1 = 14'b00000000010000,
        S_LD2  = 14'b00000000100000,
        S_MUL2 = 14'b00000001000000,
        S_LDV  = 14'b00000010000000,
        S_DIVV = 14'b00000100000000,
        S_LDM  = 14'b00001000000000,
        S_DIVM = 14'b00010000000000,
        S_LDR  = 14'b00100000000000,
        S_SQRT = 14'b01000000000000,
        S_DONE = 14'b10000000000000
    } t_state;

    t_state r_state, n_state;

    logic signed [SW-1:0]  r_max, r_min;
    logic [SUM_W-1:0]      r_sum;
    logic [SQ_W-1:0]       r_sumsq;
    logic [CNT_W-1:0]      r_count;
    logic                  r_ovf;
    logic [SW-1:0]         r_mag;
    logic                  r_last;
    logic [2*SW-1:0]       r_sq;
    logic [CNT_W-1:0]      r_n;
    logic [NSQ_W-1:0]      r_n2;
    logic [SMAG_W-1:0]     r_smag;
    logic                  r_sneg;
    logic [DIFF_W-1:0]     r_acc, r_mcand, r_d, r_tsq;
    logic [SMAG_W-1:0]     r_mplier;
    logic [DIV_W-1:0]      r_quo;
    logic [REM_W-1:0]      r_rem;
    logic [NSQ_W-1:0]      r_div;
    logic [VAR_W-1:0]      r_var;
    logic [MEAN_W-1:0]     r_mean;
    logic [ROOT_W-1:0]     r_root;
    logic [SR_W-1:0]       r_srem;
    logic [STEP_W-1:0]     r_step;
    logic                  r_out_valid;
    logic signed [IN_W-1:0]   r_o_max, r_o_min;
    logic [CNT_W-1:0]         r_o_count;
    logic signed [MEAN_W-1:0] r_o_mean;
    logic [VAR_W-1:0]         r_o_var;
    logic [STD_W-1:0]         r_o_std;
    logic                     r_o_ovf;

    logic                  w_take;
    logic                  w_room;
    logic signed [SW-1:0]  w_v;
    logic [SW-1:0]         w_mag;
    logic [2*SW-1:0]       w_prod;
    logic [CNT_W-1:0]      w_n;
    logic [NSQ_W-1:0]      w_n2;
    logic [SUM_W-1:0]      w_sabs;
    logic [DIFF_W-1:0]     w_d;
    logic [REM_W-1:0]      w_div_sh, w_div_sub;
    logic                  w_div_ge;
    logic [SR_W-1:0]       w_sr_sh, w_sr_trial, w_sr_sub;
    logic                  w_sr_ge;
    logic                  w_rem_nz;
    logic [MEAN_W-1:0]     w_q_lo;
    logic                  w_last_step;
    logic                  w_out_free;

    // Input side decode
    assign o_in_ready = (r_state == S_IDLE);
    assign w_take     = i_in_valid && o_in_ready;
    assign w_room     = (r_count < CNT_W'(MAX_COUNT));
    assign w_v        = i_sample[SW-1:0];
    assign w_mag      = w_v[SW-1] ? (~w_v + 1'b1) : w_v;
    assign w_prod     = r_mag * r_mag;

    // Set summary for the result phase
    assign w_n    = (r_count == '0) ? CNT_W'(1) : r_count;
    assign w_n2   = w_n * w_n;
    assign w_sabs = r_sum[SUM_W-1] ? (~r_sum + 1'b1) : r_sum;
    assign w_d    = r_d - r_acc;

    // Restoring divider step
    assign w_div_sh  = {r_rem[REM_W-2:0], r_quo[DIV_W-1]};
    assign w_div_ge  = (w_div_sh >= {1'b0, r_div});
    assign w_div_sub = w_div_sh - {1'b0, r_div};

    // Square root step, two radicand bits at a time
    assign w_sr_sh    = {r_srem[SR_W-3:0], r_tsq[DIFF_W-1:DIFF_W-2]};
    assign w_sr_trial = {1'b0, r_root, 2'b01};
    assign w_sr_ge    = (w_sr_sh >= w_sr_trial);
    assign w_sr_sub   = w_sr_sh - w_sr_trial;

    // Mean sign fix-up: floor for negative sums
    assign w_rem_nz = (r_rem != '0);
    assign w_q_lo   = r_quo[MEAN_W-1:0];

    assign w_last_step = (r_step == '0);
    assign w_out_free  = !r_out_valid || i_out_ready;

    // Sequencer
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (w_take) begin
                    if (w_room) begin
                        n_state = S_SQ;
                    end else if (i_last_sample) begin
                        n_state = S_PREP;
                    end
                end
            end
            S_SQ:   n_state = S_ACC;
            S_ACC:  n_state = r_last ? S_PREP : S_IDLE;
            S_PREP: n_state = S_MUL1;
            S_MUL1: if (w_last_step) n_state = S_LD2;
            S_LD2:  n_state = S_MUL2;
            S_MUL2: if (w_last_step) n_state = S_LDV;
            S_LDV:  n_state = S_DIVV;
            S_DIVV: if (w_last_step) n_state = S_LDM;
            S_LDM:  n_state = S_DIVM;
            S_DIVM: if (w_last_step) n_state = S_LDR;
            S_LDR:  n_state = S_SQRT;
            S_SQRT: if (w_last_step) n_state = S_DONE;
            S_DONE: if (w_out_free) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    // Datapath registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max   <= {1'b1, {(SW-1){1'b0}}};
            r_min   <= {1'b0, {(SW-1){1'b1}}};
            r_sum   <= '0;
            r_sumsq <= '0;
            r_count <= '0;
            r_ovf   <= 1'b0;
        end else begin
            case (r_state)
                S_IDLE: begin
                    if (w_take) begin
                        if (w_room) begin
                            if (w_v > r_max) r_max <= w_v;
                            if (w_v < r_min) r_min <= w_v;
                            r_sum   <= r_sum + SUM_W'(w_v);
                            r_count <= r_count + 1'b1;
                            r_mag   <= w_mag;
                            r_last  <= i_last_sample;
                        end else begin
                            r_ovf <= 1'b1;
                        end
                    end
                end
                S_SQ: r_sq <= w_prod;
                S_ACC: r_sumsq <= r_sumsq + SQ_W'(r_sq);
                S_PREP: begin
                    r_n      <= w_n;
                    r_n2     <= w_n2;
                    r_smag   <= w_sabs[SMAG_W-1:0];
                    r_sneg   <= r_sum[SUM_W-1];
                    r_acc    <= '0;
                    r_mcand  <= DIFF_W'(r_sumsq);
                    r_mplier <= SMAG_W'(w_n);
                    r_step   <= STEP_W'(CNT_W - 1);
                end
                S_MUL1, S_MUL2: begin
                    if (r_mplier[0]) r_acc <= r_acc + r_mcand;
                    r_mcand  <= r_mcand << 1;
                    r_mplier <= r_mplier >> 1;
                    r_step   <= r_step - 1'b1;
                end
                S_LD2: begin
                    r_d      <= r_acc;
                    r_acc    <= '0;
                    r_mcand  <= DIFF_W'(r_smag);
                    r_mplier <= r_smag;
                    r_step   <= STEP_W'(SMAG_W - 1);
                end
                S_LDV: begin
                    r_quo  <= DIV_W'(w_d) << (2 * FRAC_BITS);
                    r_div  <= r_n2;
                    r_rem  <= '0;
                    r_step <= STEP_W'(DIV_W - 1);
                end
                S_DIVV, S_DIVM: begin
                    r_rem  <= w_div_ge ? w_div_sub : w_div_sh;
                    r_quo  <= {r_quo[DIV_W-2:0], w_div_ge};
                    r_step <= r_step - 1'b1;
                end
                S_LDM: begin
                    r_var  <= r_quo[VAR_W-1+FRAC_BITS:FRAC_BITS];
                    r_tsq  <= r_quo[DIFF_W-1:0];
                    r_quo  <= DIV_W'(r_smag) << FRAC_BITS;
                    r_div  <= NSQ_W'(r_n);
                    r_rem  <= '0;
                    r_step <= STEP_W'(DIV_W - 1);
                end
                S_LDR: begin
                    r_mean <= r_sneg ? (~(w_q_lo + MEAN_W'(w_rem_nz)) + 1'b1) : w_q_lo;
                    r_root <= '0;
                    r_srem <= '0;
                    r_step <= STEP_W'(ROOT_W - 1);
                end
                S_SQRT: begin
                    r_srem <= w_sr_ge ? w_sr_sub : w_sr_sh;
                    r_root <= {r_root[ROOT_W-2:0], w_sr_ge};
                    r_tsq  <= r_tsq << 2;
                    r_step <= r_step - 1'b1;
                end
                S_DONE: begin
                    if (w_out_free) begin
                        r_o_max   <= IN_W'(r_max);
                        r_o_min   <= IN_W'(r_min);
                        r_o_count <= r_count;
                        r_o_mean  <= r_mean;
                        r_o_var   <= r_var;
                        r_o_std   <= STD_W'(r_root);
                        r_o_ovf   <= r_ovf;
                        // clear the accumulators for the next set
                        r_max   <= {1'b1, {(SW-1){1'b0}}};
                        r_min   <= {1'b0, {(SW-1){1'b1}}};
                        r_sum   <= '0;
                        r_sumsq <= '0;
                        r_count <= '0;
                        r_ovf   <= 1'b0;
                    end
                end
                default: ;
            endcase
        end
    end

    // Control state and output handshake
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if ((r_state == S_DONE) && w_out_free) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_out_valid      = r_out_valid;
    assign o_max_value      = r_o_max;
    assign o_min_value      = r_o_min;
    assign o_sample_count   = r_o_count;
    assign o_mean_fixed     = r_o_mean;
    assign o_variance_fixed = r_o_var;
    assign o_std_dev_fixed  = r_o_std;
    assign o_count_overflow = r_o_ovf;

endmodule
`default_nettype wire

### rtl/smmv_checker.sv
`default_nettype none
`include "stream_min_max_mean_variance_defines.svh"
module smmv_checker #(
    parameter int unsigned MAX_COUNT = smmv_pkg::MAX_COUNT_DEF
) (
    input logic                               i_clk,
    input logic                               i_rst_n,
    input logic                               i_in_valid,
    input logic                               o_in_ready,
    input logic signed [smmv_pkg::IN_W-1:0]   i_sample,
    input logic                               i_last_sample,
    input logic                               o_out_valid,
    input logic                               i_out_ready,
    input logic signed [smmv_pkg::IN_W-1:0]   o_max_value,
    input logic signed [smmv_pkg::IN_W-1:0]   o_min_value,
    input logic [smmv_pkg::CNT_W-1:0]         o_sample_count,
    input logic signed [smmv_pkg::MEAN_W-1:0] o_mean_fixed,
    input logic [smmv_pkg::VAR_W-1:0]         o_variance_fixed,
    input logic [smmv_pkg::STD_W-1:0]         o_std_dev_fixed,
    input logic                               o_count_overflow
);
    import smmv_pkg::*;

    logic w_in_take;
    logic w_out_stall;
    logic w_count_ok;

    assign w_in_take   = i_in_valid && o_in_ready;
    assign w_out_stall = o_out_valid && !i_out_ready;
    assign w_count_ok  = (o_sample_count != '0) &&
                         (o_sample_count <= CNT_W'(MAX_COUNT));

    // Hold a stalled result
    `SMMV_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, w_out_stall, o_out_valid && $stable(o_mean_fixed))
    // Drop ready for the cycle after a taken closing sample
    `SMMV_ASSERT_NEXT(a_busy_after_last, i_clk, i_rst_n, w_in_take && i_last_sample, !o_in_ready)
    // Count stays within the set limits
    `SMMV_ASSERT_NOW(a_count_range, i_clk, i_rst_n, o_out_valid, w_count_ok)
    // Minimum never above maximum
    `SMMV_ASSERT_NOW(a_min_le_max, i_clk, i_rst_n, o_out_valid, o_min_value <= o_max_value)

endmodule

bind stream_min_max_mean_variance smmv_checker #(.MAX_COUNT(MAX_COUNT)) u_smmv_checker (.*);
`default_nettype wire
